// ===== src/pbt_pkg.sv =====
// Shared types and constants for the peer bandwidth throttle.
// Used by pbt_div, peer_bandwidth_throttle_unit, pbt_checker and tb; no other dependencies.
`default_nettype none
package pbt_pkg;

    localparam int PEERS          = 16;
    localparam int IDX_W          = 4;
    localparam int THROTTLE_SCALE = 32;
    localparam int SCALE_SHIFT    = 5;
    localparam int INTERVAL_MS    = 1000;
    localparam int MS_PER_SEC     = 1000;
    localparam int DIV_W          = 32;
    localparam int DIV_CNT_W      = 6;

    typedef logic [31:0] word_t;
    typedef logic [5:0]  thr_t;

    // Seconds from milliseconds: (ms * SECS_RECIP) >> SECS_SHIFT is exact for any 32-bit ms.
    localparam word_t SECS_RECIP = 32'h10624DD3;
    localparam int    SECS_SHIFT = 38;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ACCOUNT = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_NOACT  = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_HOST_OUT = 2'd0,
        REG_HOST_IN  = 2'd1,
        REG_LIMITED  = 2'd2,
        REG_UNUSED   = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TSTART,
        ST_COUNT,
        ST_SECS,
        ST_SETBW,
        ST_ADJ_CHK,
        ST_ADJ_THR,
        ST_PCHK,
        ST_PMUL,
        ST_PCMP,
        ST_PDIV,
        ST_UNI_CHK,
        ST_UNI_THR,
        ST_UNI_SCAN,
        ST_RC_START,
        ST_RC_CHK,
        ST_RC_DIV,
        ST_RC_SCAN,
        ST_REPORT,
        ST_NOACT
    } state_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/peer_bandwidth_throttle_unit.sv =====
// Top level of the peer bandwidth throttle: peer table, sequencer, shared multiplier.
// Depends on pbt_pkg and on the iterative divider pbt_div.
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall  opcode .. recalc_limits
//   out       output     out_valid/out_stall report_kind .. last_report
//   cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Write and account requests each yield one acknowledge; an early tick yields a no-action report.
// A tick first checks the interval, counts the active peers and finds the seconds.
// Each limit pass may divide for the throttle, then scans the peers and divides once per
// limited peer; the uniform pass may also divide before its scan, each recalculation pass does.
// The report scan visits every peer and waits on output stalls; the shared divider dominates.
// Reset clears all tables. A full output register stalls the input.
`default_nettype none
module peer_bandwidth_throttle_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [3:0]  peer_index,
    input  wire logic        peer_active,
    input  wire logic [31:0] peer_in_bw,
    input  wire logic [31:0] peer_out_bw,
    input  wire logic [5:0]  peer_throttle_value,
    input  wire logic [15:0] sent_bytes,
    input  wire logic [31:0] now_ms,
    input  wire logic        recalc_limits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       report_kind,
    output logic [3:0]       report_peer,
    output logic [5:0]       throttle_limit_out,
    output logic [5:0]       throttle_out,
    output logic             limit_valid,
    output logic [31:0]      announced_in_bw,
    output logic             last_report,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pbt_pkg::*;

    state_t state_reg, state_next;

    word_t host_out_reg, host_in_reg;
    logic  limited_reg;

    logic  active_reg   [PEERS];
    word_t in_bw_reg    [PEERS];
    word_t out_bw_reg   [PEERS];
    word_t sent_reg     [PEERS];
    thr_t  thr_reg      [PEERS];
    thr_t  lim_reg      [PEERS];
    word_t out_ep_reg   [PEERS];
    word_t in_ep_reg    [PEERS];
    word_t epoch_reg;

    word_t now_reg, elapsed_reg, secs_reg, bw_reg, dt_reg, sum_reg;
    word_t tthr_reg, pb_reg, prod_reg, blimit_reg;
    logic  recalc_reg, adj_reg;
    logic [IDX_W:0]   rem_reg, act_cnt_reg;
    logic [IDX_W-1:0] cnt_reg, last_i_reg;

    logic  out_valid_reg, last_reg, lv_reg;
    kind_t kind_reg;
    logic [IDX_W-1:0] peer_reg;
    thr_t  olim_reg, othr_reg;
    word_t ann_reg;

    logic  out_free, push, accept, cnt_last;
    logic  act;
    word_t mul_a, mul_b, mul_res;
    logic [63:0] mul_full;
    div_req_t div_req;
    div_rsp_t div_rsp;
    thr_t  div_lim;
    logic  recalc_hit;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !(state_reg == ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cnt_last = (cnt_reg == IDX_W'(PEERS - 1));
    assign act      = active_reg[cnt_reg];

    // A peer keeps a bandwidth-derived limit only inside the saturated 1..63 range.
    assign div_lim = (div_rsp.quotient > 32'd63) ? 6'd63 :
                     ((div_rsp.quotient[5:0] == 6'd0) ? 6'd1 : div_rsp.quotient[5:0]);

    assign recalc_hit = act && (in_ep_reg[cnt_reg] != now_reg) &&
                        !((out_bw_reg[cnt_reg] != 32'd0) &&
                          (out_bw_reg[cnt_reg] >= blimit_reg));

    always_comb
    begin
        case (state_reg)
            ST_SECS:  begin mul_a = elapsed_reg;        mul_b = SECS_RECIP;        end
            ST_SETBW: begin mul_a = host_out_reg;       mul_b = secs_reg;          end
            ST_PCHK:  begin mul_a = in_bw_reg[cnt_reg]; mul_b = secs_reg;          end
            default:  begin mul_a = tthr_reg;           mul_b = sent_reg[cnt_reg]; end
        endcase
    end
    assign mul_full = {32'd0, mul_a} * {32'd0, mul_b};
    assign mul_res  = mul_full[31:0];

    pbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        push             = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = 32'(bw_reg << SCALE_SHIFT);
        div_req.divisor  = dt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_TICK)
                        state_next = ST_TSTART;
                    else
                        push = 1'b1;
                end
            end
            ST_TSTART:
                state_next = (elapsed_reg < word_t'(INTERVAL_MS)) ? ST_NOACT : ST_COUNT;
            ST_COUNT:
            begin
                if (cnt_last)
                begin
                    if (rem_reg == '0 && !act)
                        state_next = ST_NOACT;
                    else
                        state_next = ST_SECS;
                end
            end
            ST_SECS:
                state_next = ST_SETBW;
            ST_SETBW:
                state_next = ST_ADJ_CHK;
            ST_ADJ_CHK:
            begin
                if (rem_reg != '0 && adj_reg)
                begin
                    if (dt_reg <= bw_reg)
                        state_next = ST_PCHK;
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_ADJ_THR;
                    end
                end
                else
                    state_next = ST_UNI_CHK;
            end
            ST_ADJ_THR:
                if (div_rsp.done)
                    state_next = ST_PCHK;
            ST_PCHK:
            begin
                if (act && in_bw_reg[cnt_reg] != 32'd0 && out_ep_reg[cnt_reg] != now_reg)
                    state_next = ST_PMUL;
                else
                    state_next = cnt_last ? ST_ADJ_CHK : ST_PCHK;
            end
            ST_PMUL:
                state_next = ST_PCMP;
            ST_PCMP:
            begin
                if ((prod_reg >> SCALE_SHIFT) <= pb_reg || sent_reg[cnt_reg] == 32'd0)
                    state_next = cnt_last ? ST_ADJ_CHK : ST_PCHK;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 32'(pb_reg << SCALE_SHIFT);
                    div_req.divisor  = sent_reg[cnt_reg];
                    state_next       = ST_PDIV;
                end
            end
            ST_PDIV:
                if (div_rsp.done)
                    state_next = cnt_last ? ST_ADJ_CHK : ST_PCHK;
            ST_UNI_CHK:
            begin
                if (rem_reg == '0)
                    state_next = ST_RC_START;
                else if (dt_reg <= bw_reg)
                    state_next = ST_UNI_SCAN;
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_UNI_THR;
                end
            end
            ST_UNI_THR:
                if (div_rsp.done)
                    state_next = ST_UNI_SCAN;
            ST_UNI_SCAN:
                if (cnt_last)
                    state_next = ST_RC_START;
            ST_RC_START:
                state_next = (recalc_reg && host_in_reg != 32'd0) ? ST_RC_CHK : ST_REPORT;
            ST_RC_CHK:
            begin
                if (rem_reg != '0 && adj_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = bw_reg;
                    div_req.divisor  = word_t'(rem_reg);
                    state_next       = ST_RC_DIV;
                end
                else
                    state_next = ST_REPORT;
            end
            ST_RC_DIV:
                if (div_rsp.done)
                    state_next = ST_RC_SCAN;
            ST_RC_SCAN:
                if (cnt_last)
                    state_next = ST_RC_CHK;
            ST_REPORT:
            begin
                if (!act)
                    state_next = cnt_last ? ST_IDLE : ST_REPORT;
                else if (out_free)
                begin
                    push       = 1'b1;
                    state_next = cnt_last ? ST_IDLE : ST_REPORT;
                end
            end
            ST_NOACT:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers and the peer table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_out_reg <= '0;
            host_in_reg  <= '0;
            limited_reg  <= 1'b0;
            epoch_reg    <= '0;
            for (int i = 0; i < PEERS; i++)
            begin
                active_reg[i] <= 1'b0;
                in_bw_reg[i]  <= '0;
                out_bw_reg[i] <= '0;
                sent_reg[i]   <= '0;
                thr_reg[i]    <= '0;
                lim_reg[i]    <= '0;
                out_ep_reg[i] <= '0;
                in_ep_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_HOST_OUT: host_out_reg <= cfg_data;
                    REG_HOST_IN:  host_in_reg  <= cfg_data;
                    REG_LIMITED:  limited_reg  <= cfg_data[0];
                    default:      ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && opcode == OP_WRITE)
                    begin
                        active_reg[peer_index] <= peer_active;
                        in_bw_reg[peer_index]  <= peer_in_bw;
                        out_bw_reg[peer_index] <= peer_out_bw;
                        thr_reg[peer_index]    <= peer_throttle_value;
                    end
                    else if (accept && opcode == OP_ACCOUNT)
                        sent_reg[peer_index] <= sent_reg[peer_index] + {16'd0, sent_bytes};
                end
                ST_TSTART:
                    if (elapsed_reg >= word_t'(INTERVAL_MS))
                        epoch_reg <= now_reg;
                ST_PDIV:
                begin
                    if (div_rsp.done)
                    begin
                        lim_reg[cnt_reg] <= div_lim;
                        if (thr_reg[cnt_reg] > div_lim)
                            thr_reg[cnt_reg] <= div_lim;
                        out_ep_reg[cnt_reg] <= now_reg;
                        sent_reg[cnt_reg]   <= '0;
                    end
                end
                ST_UNI_SCAN:
                begin
                    if (act && out_ep_reg[cnt_reg] != now_reg)
                    begin
                        lim_reg[cnt_reg] <= (tthr_reg > 32'd63) ? 6'd63 : tthr_reg[5:0];
                        if (tthr_reg < 32'd64 && thr_reg[cnt_reg] > tthr_reg[5:0])
                            thr_reg[cnt_reg] <= tthr_reg[5:0];
                        sent_reg[cnt_reg] <= '0;
                    end
                end
                ST_RC_SCAN:
                    if (recalc_hit)
                        in_ep_reg[cnt_reg] <= now_reg;
                default: ;
            endcase
        end
    end

    // Working registers of the tick sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rem_reg <= '0;
            adj_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg     <= now_ms;
                        recalc_reg  <= recalc_limits;
                        elapsed_reg <= now_ms - epoch_reg;
                    end
                    cnt_reg    <= '0;
                    rem_reg    <= '0;
                    sum_reg    <= '0;
                    blimit_reg <= '0;
                end
                ST_COUNT:
                begin
                    if (act)
                    begin
                        rem_reg    <= rem_reg + 1'b1;
                        last_i_reg <= cnt_reg;
                        sum_reg    <= sum_reg + sent_reg[cnt_reg];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_last)
                        act_cnt_reg <= rem_reg + {{IDX_W{1'b0}}, act};
                end
                ST_SECS:
                    secs_reg <= word_t'(mul_full[63:SECS_SHIFT]);
                ST_SETBW:
                begin
                    bw_reg  <= (host_out_reg != 32'd0) ? mul_res : '1;
                    dt_reg  <= (host_out_reg != 32'd0) ? sum_reg : '1;
                    adj_reg <= limited_reg;
                end
                ST_ADJ_CHK:
                begin
                    adj_reg  <= 1'b0;
                    cnt_reg  <= '0;
                    tthr_reg <= word_t'(THROTTLE_SCALE);
                end
                ST_ADJ_THR, ST_UNI_THR:
                    if (div_rsp.done)
                        tthr_reg <= div_rsp.quotient;
                ST_PCHK:
                begin
                    pb_reg <= mul_res;
                    if (state_next != ST_PMUL)
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_PMUL:
                    prod_reg <= mul_res;
                ST_PCMP:
                    if (state_next != ST_PDIV)
                        cnt_reg <= cnt_reg + 1'b1;
                ST_PDIV:
                begin
                    if (div_rsp.done)
                    begin
                        adj_reg <= 1'b1;
                        rem_reg <= rem_reg - 1'b1;
                        bw_reg  <= bw_reg - pb_reg;
                        dt_reg  <= dt_reg - pb_reg;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_UNI_CHK:
                begin
                    cnt_reg  <= '0;
                    tthr_reg <= word_t'(THROTTLE_SCALE);
                end
                ST_UNI_SCAN:
                    cnt_reg <= cnt_reg + 1'b1;
                ST_RC_START:
                begin
                    rem_reg <= act_cnt_reg;
                    bw_reg  <= host_in_reg;
                    adj_reg <= 1'b1;
                    cnt_reg <= '0;
                end
                ST_RC_CHK:
                begin
                    adj_reg <= 1'b0;
                    cnt_reg <= '0;
                end
                ST_RC_DIV:
                    if (div_rsp.done)
                        blimit_reg <= div_rsp.quotient;
                ST_RC_SCAN:
                begin
                    if (recalc_hit)
                    begin
                        adj_reg <= 1'b1;
                        rem_reg <= rem_reg - 1'b1;
                        bw_reg  <= bw_reg - out_bw_reg[cnt_reg];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_REPORT:
                    if (!act || out_free)
                        cnt_reg <= cnt_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // Output register; a report is loaded only while the slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    kind_reg <= KIND_ACK;
                    peer_reg <= peer_index;
                    olim_reg <= lim_reg[peer_index];
                    othr_reg <= (opcode == OP_WRITE) ? peer_throttle_value
                                                     : thr_reg[peer_index];
                    lv_reg   <= 1'b0;
                    ann_reg  <= '0;
                    last_reg <= 1'b1;
                end
                ST_REPORT:
                begin
                    kind_reg <= KIND_REPORT;
                    peer_reg <= cnt_reg;
                    olim_reg <= lim_reg[cnt_reg];
                    othr_reg <= thr_reg[cnt_reg];
                    lv_reg   <= recalc_reg;
                    ann_reg  <= !recalc_reg ? '0 :
                                ((in_ep_reg[cnt_reg] == now_reg) ? out_bw_reg[cnt_reg]
                                                                 : blimit_reg);
                    last_reg <= (cnt_reg == last_i_reg);
                end
                default:
                begin
                    kind_reg <= KIND_NOACT;
                    peer_reg <= '0;
                    olim_reg <= '0;
                    othr_reg <= '0;
                    lv_reg   <= 1'b0;
                    ann_reg  <= '0;
                    last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign report_kind        = kind_reg;
    assign report_peer        = peer_reg;
    assign throttle_limit_out = olim_reg;
    assign throttle_out       = othr_reg;
    assign limit_valid        = lv_reg;
    assign announced_in_bw    = ann_reg;
    assign last_report        = last_reg;

endmodule
`default_nettype wire

// ===== src/pbt_div.sv =====
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
// Depends on pbt_pkg for the request and response structs.
`default_nettype none
module pbt_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pbt_pkg::div_req_t req,
    output pbt_pkg::div_rsp_t      rsp
);
    import pbt_pkg::*;

    logic [DIV_W:0]     rem_reg, rem_next;
    word_t              quo_reg, quo_next;
    word_t              dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

// ===== dv/pbt_checker.sv =====
// Checker for peer_bandwidth_throttle_unit: watches the request, report and register
// channels, predicts the reports of every accepted request and compares them.
// Depends on pbt_pkg.
`timescale 1ns / 1ps
module pbt_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [3:0]  peer_index,
    input  wire logic        peer_active,
    input  wire logic [31:0] peer_in_bw,
    input  wire logic [31:0] peer_out_bw,
    input  wire logic [5:0]  peer_throttle_value,
    input  wire logic [15:0] sent_bytes,
    input  wire logic [31:0] now_ms,
    input  wire logic        recalc_limits,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  report_kind,
    input  wire logic [3:0]  report_peer,
    input  wire logic [5:0]  throttle_limit_out,
    input  wire logic [5:0]  throttle_out,
    input  wire logic        limit_valid,
    input  wire logic [31:0] announced_in_bw,
    input  wire logic        last_report,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending
);
    import pbt_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  peer;
        thr_t        lim;
        thr_t        thr;
        logic        valid;
        word_t       ann;
        logic        last;
    } report_t;

    report_t reports_due[$];

    word_t  host_out, host_in;
    logic   limited;
    logic   act [PEERS];
    word_t  in_bw [PEERS], out_bw [PEERS], sent [PEERS];
    thr_t   thr_tab [PEERS], lim_tab [PEERS];
    word_t  out_ep [PEERS], in_ep [PEERS];
    word_t  epoch;

    assign pending = reports_due.size();

    function automatic thr_t clamp63(word_t v);
        return (v > 63) ? 6'd63 : v[5:0];
    endfunction

    task automatic push(kind_t k, int p, thr_t l, thr_t t, logic v, word_t a, logic ls);
        report_t r;
        r.kind = k; r.peer = p[3:0]; r.lim = l; r.thr = t;
        r.valid = v; r.ann = a; r.last = ls;
        reports_due.push_back(r);
    endtask

    task automatic apply_limit(int i, thr_t l);
        lim_tab[i] = l;
        if (thr_tab[i] > l)
            thr_tab[i] = l;
    endtask

    task automatic run_tick(word_t now, logic recalc);
        word_t elapsed, remaining, total, bw, thr, secs, blimit, pb, odt;
        logic  adj;
        int    last_i;
        thr_t  l;
        elapsed = now - epoch;
        remaining = 0; total = '1; bw = '1; blimit = 0; last_i = -1;
        if (elapsed < INTERVAL_MS) begin
            push(KIND_NOACT, 0, 0, 0, 0, 0, 1);
            return;
        end
        epoch = now;
        for (int i = 0; i < PEERS; i++)
            if (act[i])
            begin
                remaining++;
                last_i = i;
            end
        if (remaining == 0) begin
            push(KIND_NOACT, 0, 0, 0, 0, 0, 1);
            return;
        end
        secs = elapsed / MS_PER_SEC;
        if (host_out != 0) begin
            total = 0;
            bw = host_out * secs;
            for (int i = 0; i < PEERS; i++)
                if (act[i])
                    total += sent[i];
        end
        adj = limited;
        while (remaining > 0 && adj) begin
            adj = 0;
            thr = (total <= bw) ? THROTTLE_SCALE : (bw * THROTTLE_SCALE) / total;
            for (int i = 0; i < PEERS; i++) begin
                odt = sent[i];
                if (!act[i] || in_bw[i] == 0 || out_ep[i] == now)
                    continue;
                pb = in_bw[i] * secs;
                if ((thr * odt) / THROTTLE_SCALE <= pb || odt == 0)
                    continue;
                l = clamp63((pb * THROTTLE_SCALE) / odt);
                if (l == 0)
                    l = 1;
                apply_limit(i, l);
                out_ep[i] = now;
                sent[i] = 0;
                adj = 1;
                remaining--;
                bw -= pb;
                total -= pb;
            end
        end
        if (remaining > 0) begin
            thr = (total <= bw) ? THROTTLE_SCALE : (bw * THROTTLE_SCALE) / total;
            for (int i = 0; i < PEERS; i++) begin
                if (!act[i] || out_ep[i] == now)
                    continue;
                apply_limit(i, clamp63(thr));
                sent[i] = 0;
            end
        end
        if (recalc) begin
            remaining = 0;
            for (int i = 0; i < PEERS; i++)
                if (act[i])
                    remaining++;
            bw = host_in;
            adj = 1;
            if (bw != 0) begin
                while (remaining > 0 && adj) begin
                    adj = 0;
                    blimit = bw / remaining;
                    for (int i = 0; i < PEERS; i++) begin
                        if (!act[i] || in_ep[i] == now)
                            continue;
                        if (out_bw[i] > 0 && out_bw[i] >= blimit)
                            continue;
                        in_ep[i] = now;
                        adj = 1;
                        remaining--;
                        bw -= out_bw[i];
                    end
                end
            end
        end
        for (int i = 0; i < PEERS; i++) begin
            if (!act[i])
                continue;
            push(KIND_REPORT, i, lim_tab[i], thr_tab[i], recalc,
                 recalc ? ((in_ep[i] == now) ? out_bw[i] : blimit) : 32'd0, i == last_i);
        end
    endtask

    task automatic take_request();
        int idx;
        idx = peer_index;
        case (opcode)
            OP_TICK: run_tick(now_ms, recalc_limits);
            default:
            begin
                if (opcode == OP_WRITE) begin
                    act[idx] = peer_active;
                    in_bw[idx] = peer_in_bw;
                    out_bw[idx] = peer_out_bw;
                    thr_tab[idx] = peer_throttle_value;
                end else if (opcode == OP_ACCOUNT) begin
                    sent[idx] += {16'd0, sent_bytes};
                end
                push(KIND_ACK, idx, lim_tab[idx], thr_tab[idx], 0, 0, 1);
            end
        endcase
    endtask

    task automatic check_report();
        report_t e;
        if (reports_due.size() == 0) begin
            $error("unexpected report kind %0d peer %0d", report_kind, report_peer);
            errors++;
            return;
        end
        e = reports_due.pop_front();
        if (report_kind != e.kind) begin
            $error("report_kind expected %0d actual %0d", e.kind, report_kind); errors++;
        end
        if (report_peer != e.peer) begin
            $error("report_peer expected %0d actual %0d", e.peer, report_peer); errors++;
        end
        if (throttle_limit_out != e.lim) begin
            $error("throttle_limit_out expected %0d actual %0d", e.lim, throttle_limit_out);
            errors++;
        end
        if (throttle_out != e.thr) begin
            $error("throttle_out expected %0d actual %0d", e.thr, throttle_out); errors++;
        end
        if (limit_valid != e.valid) begin
            $error("limit_valid expected %0d actual %0d", e.valid, limit_valid); errors++;
        end
        if (announced_in_bw != e.ann) begin
            $error("announced_in_bw expected %0d actual %0d", e.ann, announced_in_bw);
            errors++;
        end
        if (last_report != e.last) begin
            $error("last_report expected %0d actual %0d", e.last, last_report); errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            errors = 0;
            host_out = 0; host_in = 0; limited = 0; epoch = 0;
            for (int i = 0; i < PEERS; i++) begin
                act[i] = 0; in_bw[i] = 0; out_bw[i] = 0; sent[i] = 0;
                thr_tab[i] = 0; lim_tab[i] = 0; out_ep[i] = 0; in_ep[i] = 0;
            end
            reports_due.delete();
        end else begin
            if (out_valid && !out_stall)
                check_report();
            if (in_valid && !in_stall)
                take_request();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HOST_OUT: host_out = cfg_data;
                    REG_HOST_IN:  host_in = cfg_data;
                    REG_LIMITED:  limited = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== dv/tb.sv =====
// Top of the peer_bandwidth_throttle_unit testbench: clock, reset, stimulus and verdict.
// Depends on pbt_pkg, the block itself and the pbt_checker module.
`timescale 1ns / 1ps
module tb;
    import pbt_pkg::*;

    logic        clk = 0, rst_n = 0;
    logic        in_valid = 0, out_stall = 0, cfg_valid = 0;
    logic [1:0]  opcode = 0, cfg_index = 0;
    logic [3:0]  peer_index = 0;
    logic        peer_active = 0, recalc_limits = 0;
    logic [31:0] peer_in_bw = 0, peer_out_bw = 0, now_ms = 0, cfg_data = 0;
    logic [5:0]  peer_throttle_value = 0;
    logic [15:0] sent_bytes = 0;
    wire         in_stall, out_valid, limit_valid, last_report, cfg_ready;
    wire  [1:0]  report_kind;
    wire  [3:0]  report_peer;
    wire  [5:0]  throttle_limit_out, throttle_out;
    wire  [31:0] announced_in_bw;
    int          errors, pending;
    int          cycles = 0;
    logic        hold_off = 0;
    logic [31:0] clock_ms = 0;

    localparam int CYCLE_LIMIT = 20000000;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    peer_bandwidth_throttle_unit uut (.*);
    pbt_checker chk (.*);

    // Receiver: random stall pattern, quiet stretches, and one long hold-off.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (hold_off)
            out_stall <= 1;
        else if (cycles % 3000 < 600)
            out_stall <= 0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    initial begin
        wait (rst_n);
        repeat (2000) @(posedge clk);
        hold_off <= 1;
        repeat (1500) @(posedge clk);
        hold_off <= 0;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("peer_bandwidth_throttle_unit regression: fail");
        $finish;
    end

    task automatic write_reg(cfg_idx_t r, logic [31:0] v);
        cfg_index <= r;
        cfg_data  <= v;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (pending != 0 || in_valid) @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    // Presents one request; in_valid stays high across back-to-back requests.
    task automatic send(opcode_t op, int idx, logic a, logic [31:0] ib, logic [31:0] ob,
                        logic [5:0] tv, logic [15:0] sb, logic [31:0] nm, logic rc);
        opcode <= op; peer_index <= 4'(idx); peer_active <= a;
        peer_in_bw <= ib; peer_out_bw <= ob; peer_throttle_value <= tv;
        sent_bytes <= sb; now_ms <= nm; recalc_limits <= rc;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic gap();
        in_valid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    task automatic rand_write(int idx);
        logic [5:0] tv;
        tv = 6'($urandom_range(0, 32));
        send(OP_WRITE, idx, $urandom_range(0, 5) != 0,
             ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000),
             ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000),
             tv, 16'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic rand_tick();
        logic [31:0] step;
        case ($urandom_range(0, 5))
            0: step = $urandom_range(0, 999);
            1: step = $urandom;
            default: step = $urandom_range(1000, 5000);
        endcase
        clock_ms = clock_ms + step;
        send(OP_TICK, $urandom, 1'($urandom), $urandom, $urandom, 6'($urandom),
             16'($urandom), clock_ms, 1'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, each operation, early and empty ticks.
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 32'd5000, 1);
        send(OP_NONE, 15, 1, '1, '1, 63, '1, '1, 1);
        send(OP_WRITE, 0, 1, '1, '1, 32, 0, 0, 0);
        send(OP_WRITE, 15, 1, 0, 0, 0, 0, 0, 0);
        send(OP_WRITE, 7, 1, 100, 0, 20, 0, 0, 0);
        send(OP_ACCOUNT, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0);
        send(OP_ACCOUNT, 7, 0, 0, 0, 0, 16'hFFFF, 0, 0);
        send(OP_ACCOUNT, 15, 0, 0, 0, 0, 16'h1234, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 32'd5500, 0);
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 32'd9000, 1);
        gap();
        drain();
        write_reg(REG_HOST_OUT, 1000);
        write_reg(REG_HOST_IN, 5000);
        write_reg(REG_LIMITED, 1);
        send(OP_ACCOUNT, 7, 0, 0, 0, 0, 16'hFFFF, 0, 0);
        send(OP_ACCOUNT, 0, 0, 0, 0, 0, 16'd500, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 32'd12000, 1);
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1);
        clock_ms = 32'hFFFF_FFFF;
        gap();
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(REG_HOST_OUT, '1); write_reg(REG_HOST_IN, '1); end
                1: begin write_reg(REG_HOST_OUT, 0); write_reg(REG_HOST_IN, 0); end
                2: begin write_reg(REG_LIMITED, 0); write_reg(REG_HOST_OUT, 3000); end
                3: begin write_reg(REG_LIMITED, 1); write_reg(REG_HOST_IN, 40000); end
                4: begin write_reg(REG_HOST_OUT, $urandom); write_reg(REG_HOST_IN, $urandom); end
                default: write_reg(REG_HOST_OUT, 50);
            endcase
            for (int n = 0; n < 80; ) begin
                for (int b = $urandom_range(1, 12); b > 0; b--) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: rand_write($urandom_range(0, 15));
                        3, 4, 5, 6: send(OP_ACCOUNT, $urandom, 1'($urandom), $urandom,
                                         $urandom, 6'($urandom), 16'($urandom), $urandom,
                                         1'($urandom));
                        7, 8: rand_tick();
                        default: send(OP_NONE, $urandom, 1'($urandom), $urandom, $urandom,
                                      6'($urandom), 16'($urandom), $urandom, 1'($urandom));
                    endcase
                    n++;
                end
                if ($urandom_range(0, 2) != 0)
                    gap();
            end
            gap();
            drain();
        end

        if (errors == 0)
            $display("peer_bandwidth_throttle_unit regression: pass");
        else
            $display("peer_bandwidth_throttle_unit regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
src/pbt_pkg.sv
src/pbt_div.sv
src/peer_bandwidth_throttle_unit.sv
dv/pbt_checker.sv
dv/tb.sv
